### sv/assert_macros.svh
// assertion macros shared by the segmenter rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

### sv/mrfs_pkg.sv
// types, constants and helpers for the reply frame segmenter
// used by mrfs_front, mrfs_back and the top level
package mrfs_pkg;

    localparam int MAX_FRAME_LENGTH = 32;
    localparam int FLEN_W           = 6;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = 2;

    localparam logic [FLEN_W-1:0] FLEN_RESET = 6'd6;
    localparam logic [FLEN_W-1:0] FLEN_MIN   = 6'd2;
    localparam logic [FLEN_W-1:0] FLEN_MAX   = FLEN_W'(MAX_FRAME_LENGTH);

    localparam logic [7:0] HDR_START = 8'h10;
    localparam logic [7:0] HDR_ERROR = 8'h20;
    localparam logic [3:0] SEQ_MASK  = 4'hF;

    // register index decoded from paddr[2]
    localparam logic REG_FRAME_LENGTH = 1'b0;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef enum logic {
        K_START = 1'b0,
        K_DATA  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] cmd;
        logic [7:0] rlen;
        logic       err;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    function automatic logic [FLEN_W-1:0] clamp_len(input logic [FLEN_W-1:0] raw);
        logic [FLEN_W-1:0] l;
        l = raw;
        if (l < FLEN_MIN) l = FLEN_MIN;
        if (l > FLEN_MAX) l = FLEN_MAX;
        return l;
    endfunction

endpackage

### sv/msp_reply_frame_segmenter_core.sv
// top level of the reply frame segmenter: config register, front queue, back engine
// depends on mrfs_pkg, mrfs_front and mrfs_back
// an accepted item is registered in the front queue, from which the idle back end
//   dispatches it; the item's first byte is registered at the output after dispatch,
//   then one byte per cycle unless m_axis_tready stalls; an item costs the engine a
//   dispatch plus one output register load per byte, and ignored data is only popped
// reset: synchronous active low, clears queue and frame state, frame_length to 6
module msp_reply_frame_segmenter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // reply_cmd, reply_length, reply_error, data_byte
    input  logic        s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte
    output logic        m_axis_tlast,  // end_of_frame
    output logic [1:0]  m_axis_tuser,  // last_of_run, end_of_reply
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mrfs_pkg::*;

    logic [FLEN_W-1:0] r_frame_length;
    t_q_head           head;
    logic              pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= FLEN_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_LENGTH)) begin
            r_frame_length <= pwdata[FLEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_FRAME_LENGTH) ? {{(32-FLEN_W){1'b0}}, r_frame_length}
                                                   : 32'h0;

    mrfs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_pop         (pop),
        .o_head        (head)
    );

    mrfs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_length (r_frame_length),
        .i_head         (head),
        .o_pop          (pop),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tuser   (m_axis_tuser)
    );

endmodule

### sv/mrfs_front.sv
// front end: accepts input transactions, classifies them and queues them
// depends on mrfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module mrfs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,  // reply_cmd, reply_length, reply_error, data_byte
    input  logic              s_axis_tuser,  // opcode
    input  logic              i_pop,
    output mrfs_pkg::t_q_head o_head
);
    import mrfs_pkg::*;

    t_item                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr;
    logic [QUEUE_AW-1:0]   r_rd;
    logic [QUEUE_AW:0]     r_count;
    logic                  push;
    logic                  pop;
    t_item                 in_item;

    assign s_axis_tready = (r_count < (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = i_pop && (r_count != '0);

    always_comb begin
        in_item.kind = (s_axis_tuser == OP_DATA) ? K_DATA : K_START;
        in_item.cmd  = s_axis_tdata[7:0];
        in_item.rlen = s_axis_tdata[15:8];
        in_item.err  = s_axis_tdata[16];
        in_item.data = s_axis_tdata[24:17];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd];

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_ptr_gap, i_clk, i_rst_n, (r_count == '0) || (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH)), r_wr == r_rd)

endmodule

### sv/mrfs_back.sv
// back end: turns queued items into frame bytes, one byte per transaction
// depends on mrfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module mrfs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mrfs_pkg::FLEN_W-1:0] i_frame_length,
    input  mrfs_pkg::t_q_head           i_head,
    output logic                        o_pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,  // out_byte
    output logic                        m_axis_tlast,  // end_of_frame
    output logic [1:0]                  m_axis_tuser   // last_of_run, end_of_reply
);
    import mrfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHDR,
        S_SLEN,
        S_DHDR,
        S_DATA,
        S_FHDR,
        S_CSUM,
        S_PAD
    } t_state;

    t_state            r_state;
    logic [3:0]        r_seq;
    logic [7:0]        r_csum;
    logic [7:0]        r_bl;
    logic [FLEN_W-1:0] r_fp;
    logic              r_open;
    logic [7:0]        r_rlen;
    logic              r_err;
    logic [7:0]        r_data;

    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_eof;
    logic              r_out_eor;
    logic              r_out_last;

    logic [FLEN_W-1:0] len;
    logic              adv;
    logic [7:0]        new_bl;
    logic [7:0]        em_byte;
    logic [8:0]        em_after;
    logic [FLEN_W-1:0] fp_inc;
    logic              eof;
    logic              eor;
    logic [FLEN_W-1:0] fp_norm;

    assign len     = clamp_len(i_frame_length);
    assign adv     = !r_out_valid || m_axis_tready;
    assign o_pop   = (r_state == S_IDLE) && i_head.valid;
    assign new_bl  = r_bl - 8'd1;
    assign fp_inc  = r_fp + 1'b1;
    assign eof     = (fp_inc >= len);
    assign fp_norm = (r_fp >= len) ? '0 : r_fp;

    always_comb begin
        em_byte  = 8'h00;
        em_after = 9'd0;
        unique case (r_state)
            S_SHDR: begin
                em_byte  = HDR_START | {4'b0, r_seq & SEQ_MASK} | (r_err ? HDR_ERROR : 8'h00);
                em_after = {1'b0, r_rlen} + 9'd2;
            end
            S_SLEN: begin
                em_byte  = r_rlen;
                em_after = {1'b0, r_rlen} + 9'd1;
            end
            S_DHDR: begin
                em_byte  = {4'b0, r_seq & SEQ_MASK};
                em_after = {1'b0, r_bl} + 9'd1;
            end
            S_DATA: begin
                em_byte  = r_data;
                em_after = {1'b0, new_bl} + 9'd1;
            end
            S_FHDR: begin
                em_byte  = {4'b0, r_seq & SEQ_MASK};
                em_after = 9'd1;
            end
            S_CSUM: begin
                em_byte  = r_csum;
                em_after = 9'd0;
            end
            S_PAD, S_IDLE: begin
                em_byte  = 8'h00;
                em_after = 9'd0;
            end
            default: begin
                em_byte  = 8'h00;
                em_after = 9'd0;
            end
        endcase
    end

    assign eor = (({4'b0, r_fp} + 10'd1 + {1'b0, em_after}) <= {4'b0, len});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seq       <= '0;
            r_csum      <= '0;
            r_bl        <= '0;
            r_fp        <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_IDLE) begin
                if (m_axis_tready) r_out_valid <= 1'b0;
                if (i_head.valid) begin
                    if (i_head.item.kind == K_START) begin
                        r_rlen  <= i_head.item.rlen;
                        r_err   <= i_head.item.err;
                        r_bl    <= i_head.item.rlen;
                        r_csum  <= i_head.item.rlen ^ i_head.item.cmd;
                        r_open  <= 1'b1;
                        r_fp    <= '0;
                        r_state <= S_SHDR;
                    end else if (r_open) begin
                        r_data  <= i_head.item.data;
                        r_fp    <= fp_norm;
                        r_state <= (fp_norm == '0) ? S_DHDR : S_DATA;
                    end
                end
            end else if (adv) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= em_byte;
                r_out_eof   <= eof;
                r_out_eor   <= eor;
                r_fp        <= eof ? '0 : fp_inc;
                unique case (r_state)
                    S_SHDR: begin
                        r_out_last <= 1'b0;
                        r_seq      <= r_seq + 1'b1;
                        r_state    <= S_SLEN;
                    end
                    S_SLEN: begin
                        r_out_last <= (r_rlen != 8'd0);
                        if (r_rlen == 8'd0) r_state <= eof ? S_FHDR : S_CSUM;
                        else                r_state <= S_IDLE;
                    end
                    S_DHDR: begin
                        r_out_last <= 1'b0;
                        r_seq      <= r_seq + 1'b1;
                        r_state    <= S_DATA;
                    end
                    S_DATA: begin
                        r_bl       <= new_bl;
                        r_csum     <= r_csum ^ r_data;
                        r_out_last <= (new_bl != 8'd0);
                        if (new_bl == 8'd0) r_state <= eof ? S_FHDR : S_CSUM;
                        else                r_state <= S_IDLE;
                    end
                    S_FHDR: begin
                        r_out_last <= 1'b0;
                        r_seq      <= r_seq + 1'b1;
                        r_state    <= S_CSUM;
                    end
                    S_CSUM, S_PAD: begin
                        r_out_last <= eof;
                        if (eof) begin
                            r_open  <= 1'b0;
                            r_bl    <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_PAD;
                        end
                    end
                    default: begin
                        r_out_last <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_eof;
    assign m_axis_tuser  = {r_out_last, r_out_eor};

    `ASSERT_IMPLIES(a_busy_open, i_clk, i_rst_n, r_state != S_IDLE, r_open)
    `ASSERT_IMPLIES(a_eof_pos, i_clk, i_rst_n, r_out_valid && r_out_eof, r_fp == '0)

endmodule
